@@ rtl/tftp_transfer_engine_defines.svh @@
// ----------------------------------------------------------------------------
// tftp transfer engine assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TFTP_TRANSFER_ENGINE_DEFINES_SVH
`define TFTP_TRANSFER_ENGINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tte_pkg.sv @@
// ----------------------------------------------------------------------------
// tte_pkg
// types, codes and helpers of the tftp transfer engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

    localparam int unsigned BLK_W   = 16;
    localparam int unsigned LEN_W   = 11;
    localparam int unsigned TICK_W  = 8;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_PKT   = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_CHUNK = 2'd3;

    localparam logic [7:0] TYPE_DATA  = 8'd3;
    localparam logic [7:0] TYPE_ACK   = 8'd4;
    localparam logic [7:0] TYPE_ERROR = 8'd5;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_WAIT_CHUNK = 3'd1;
    localparam logic [2:0] PH_WAIT_ACK   = 3'd2;
    localparam logic [2:0] PH_RECEIVE    = 3'd3;
    localparam logic [2:0] PH_DONE       = 3'd4;
    localparam logic [2:0] PH_SILENT     = 3'd5;
    localparam logic [2:0] PH_PEER_ERR   = 3'd6;

    localparam logic [2:0] ST_ACTIVE   = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_DONE     = 3'd2;
    localparam logic [2:0] ST_SILENT   = 3'd3;
    localparam logic [2:0] ST_PEER_ERR = 3'd4;

    localparam logic [1:0] REG_DIRECTION  = 2'd0;
    localparam logic [1:0] REG_SILENCE    = 2'd1;
    localparam logic [1:0] REG_BLOCK_SIZE = 2'd2;

    localparam logic [TICK_W-1:0] SILENCE_RST = 8'd10;
    localparam logic [LEN_W-1:0]  BSIZE_RST   = 11'd512;
    localparam logic [LEN_W-1:0]  BSIZE_MIN   = 11'd8;
    localparam logic [LEN_W-1:0]  BSIZE_MAX   = 11'd1024;
    localparam logic [LEN_W-1:0]  HDR_LEN     = 11'd4;

    typedef struct packed {
        logic              direction;
        logic [TICK_W-1:0] silence_limit;
        logic [LEN_W-1:0]  block_size;
    } t_cfg;

    typedef struct packed {
        logic [LEN_W-1:0] chunk_length;
        logic             from_peer;
        logic [BLK_W-1:0] packet_block;
        logic [7:0]       type_byte;
        logic [LEN_W-1:0] packet_length;
        logic [1:0]       op;
    } t_item;

    typedef struct packed {
        logic [2:0]       status;
        logic             want_chunk;
        logic             store_payload;
        logic [LEN_W-1:0] send_length;
        logic [BLK_W-1:0] send_block;
        logic [1:0]       send_kind;
    } t_result;

    function automatic logic [2:0] status_of(input logic [2:0] ph);
        logic [2:0] st;
        case (ph)
            PH_IDLE:     st = ST_IDLE;
            PH_DONE:     st = ST_DONE;
            PH_SILENT:   st = ST_SILENT;
            PH_PEER_ERR: st = ST_PEER_ERR;
            default:     st = ST_ACTIVE;
        endcase
        return st;
    endfunction

    function automatic logic [LEN_W-1:0] clamp_bsize(input logic [LEN_W-1:0] bs);
        logic [LEN_W-1:0] r;
        if (bs < BSIZE_MIN) r = BSIZE_MIN;
        else if (bs > BSIZE_MAX) r = BSIZE_MAX;
        else r = bs;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/tftp_transfer_engine.sv @@
// ----------------------------------------------------------------------------
// tftp_transfer_engine: stop-and-wait tftp transfer control, one session
// path: an accepted request is held in the input request register, its result in the result register on m_tdata
// throughput: one request per cycle unless m_tready stalls the result, set by the single-pass update in tte_core
// reset: synchronous active low, session idle, registers at their defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tftp_transfer_engine import tte_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // packet_length, type_byte, packet_block, from_peer, chunk_length, zero pad
    input  wire logic [47:0] s_tdata,
    // op
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // send_block, send_length, store_payload, want_chunk, status
    output logic      [31:0] m_tdata,
    // send_kind
    output logic      [1:0]  m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_vld;
    t_result res;
    t_result r_res;
    logic    r_out_vld;
    logic    advance;

    tte_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign advance  = r_in_vld & (~r_out_vld | m_tready);
    assign s_tready = ~r_in_vld | advance;

    // input request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_tready) begin
            r_in_vld <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_item <= '{chunk_length:  s_tdata[46:36],
                        from_peer:     s_tdata[35],
                        packet_block:  s_tdata[34:19],
                        type_byte:     s_tdata[18:11],
                        packet_length: s_tdata[10:0],
                        op:            s_tuser};
        end
    end

    tte_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= res;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tuser  = r_res.send_kind;
    assign m_tdata  = {r_res.status, r_res.want_chunk, r_res.store_payload,
                       r_res.send_length, r_res.send_block};

endmodule

`default_nettype wire

@@ rtl/tte_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tte_cfg_regs
// apb register file: direction, silence limit, block size
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tte_cfg_regs import tte_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic              r_direction;
    logic [TICK_W-1:0] r_silence;
    logic [LEN_W-1:0]  r_block_size;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction  <= 1'b0;
            r_silence    <= SILENCE_RST;
            r_block_size <= BSIZE_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_DIRECTION:  r_direction  <= pwdata[0];
                REG_SILENCE:    r_silence    <= pwdata[TICK_W-1:0];
                REG_BLOCK_SIZE: r_block_size <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DIRECTION:  prdata = {31'd0, r_direction};
            REG_SILENCE:    prdata = {{(32-TICK_W){1'b0}}, r_silence};
            REG_BLOCK_SIZE: prdata = {{(32-LEN_W){1'b0}}, r_block_size};
            default:        prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{direction: r_direction, silence_limit: r_silence,
                     block_size: r_block_size};

endmodule

`default_nettype wire

@@ rtl/tte_core.sv @@
// ----------------------------------------------------------------------------
// tte_core
// session state and single-pass next-state and result logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tte_core import tte_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_result    o_res
);

    logic [2:0]        r_phase,   n_phase;
    logic [BLK_W-1:0]  r_blk_cnt, n_blk_cnt;
    logic [TICK_W-1:0] r_elapsed, n_elapsed;
    logic [1:0]        r_last_kind, n_last_kind;
    logic [BLK_W-1:0]  r_last_blk,  n_last_blk;
    logic [LEN_W-1:0]  r_last_len,  n_last_len;
    logic              r_short,     n_short;

    logic [LEN_W-1:0]  bs;
    logic [LEN_W-1:0]  clen;
    logic [LEN_W-1:0]  dlen;
    logic              in_session;

    assign bs         = clamp_bsize(i_cfg.block_size);
    assign clen       = (i_item.chunk_length > bs) ? bs : i_item.chunk_length;
    assign dlen       = i_item.packet_length - HDR_LEN;
    assign in_session = r_phase inside {PH_WAIT_ACK, PH_RECEIVE};

    always_comb begin
        n_phase     = r_phase;
        n_blk_cnt   = r_blk_cnt;
        n_elapsed   = r_elapsed;
        n_last_kind = r_last_kind;
        n_last_blk  = r_last_blk;
        n_last_len  = r_last_len;
        n_short     = r_short;
        o_res       = '0;

        case (i_item.op)
            OP_START: begin
                n_blk_cnt  = 16'd1;
                n_elapsed  = '0;
                n_short    = 1'b0;
                n_last_blk = '0;
                n_last_len = '0;
                if (!i_cfg.direction) begin
                    n_last_kind      = KIND_NONE;
                    n_phase          = PH_WAIT_CHUNK;
                    o_res.want_chunk = 1'b1;
                end else begin
                    n_last_kind     = KIND_ACK;
                    n_phase         = PH_RECEIVE;
                    o_res.send_kind = KIND_ACK;
                end
            end
            OP_CHUNK: begin
                if (r_phase == PH_WAIT_CHUNK) begin
                    n_short           = clen < bs;
                    n_last_kind       = KIND_DATA;
                    n_last_blk        = r_blk_cnt;
                    n_last_len        = clen;
                    o_res.send_kind   = KIND_DATA;
                    o_res.send_block  = r_blk_cnt;
                    o_res.send_length = clen;
                    n_elapsed         = '0;
                    n_phase           = PH_WAIT_ACK;
                end
            end
            OP_TICK: begin
                if (in_session) begin
                    if (r_elapsed != {TICK_W{1'b1}}) n_elapsed = r_elapsed + 8'd1;
                    if (n_elapsed >= i_cfg.silence_limit) begin
                        n_phase = PH_SILENT;
                    end else if (r_last_kind != KIND_NONE) begin
                        o_res.send_kind   = r_last_kind;
                        o_res.send_block  = r_last_blk;
                        o_res.send_length = (r_last_kind == KIND_DATA) ? r_last_len : '0;
                    end
                end
            end
            default: begin
                if (i_item.from_peer && in_session) begin
                    n_elapsed = '0;
                    if (i_item.packet_length >= HDR_LEN) begin
                        if (i_item.type_byte == TYPE_ERROR) begin
                            n_phase = PH_PEER_ERR;
                        end else if (r_phase == PH_WAIT_ACK && i_item.type_byte == TYPE_ACK) begin
                            if (i_item.packet_block == r_blk_cnt) begin
                                n_blk_cnt = r_blk_cnt + 16'd1;
                                if (r_short) begin
                                    n_phase = PH_DONE;
                                end else begin
                                    n_phase          = PH_WAIT_CHUNK;
                                    o_res.want_chunk = 1'b1;
                                end
                            end
                        end else if (r_phase == PH_RECEIVE && i_item.type_byte == TYPE_DATA) begin
                            if (i_item.packet_block == r_blk_cnt) begin
                                o_res.store_payload = dlen != '0;
                                n_last_kind         = KIND_ACK;
                                n_last_blk          = i_item.packet_block;
                                n_last_len          = '0;
                                o_res.send_kind     = KIND_ACK;
                                o_res.send_block    = i_item.packet_block;
                                n_blk_cnt           = r_blk_cnt + 16'd1;
                                if (dlen < bs) n_phase = PH_DONE;
                            end else if (i_item.packet_block < r_blk_cnt) begin
                                n_last_kind      = KIND_ACK;
                                n_last_blk       = i_item.packet_block;
                                n_last_len       = '0;
                                o_res.send_kind  = KIND_ACK;
                                o_res.send_block = i_item.packet_block;
                            end
                        end
                    end
                end
            end
        endcase

        o_res.status = status_of(n_phase);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_blk_cnt   <= '0;
            r_elapsed   <= '0;
            r_last_kind <= KIND_NONE;
            r_last_blk  <= '0;
            r_last_len  <= '0;
            r_short     <= 1'b0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_blk_cnt   <= n_blk_cnt;
            r_elapsed   <= n_elapsed;
            r_last_kind <= n_last_kind;
            r_last_blk  <= n_last_blk;
            r_last_len  <= n_last_len;
            r_short     <= n_short;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tte_checker.sv @@
// ----------------------------------------------------------------------------
// tte_checker
// port-level checks on the result stream of the transfer engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tftp_transfer_engine_defines.svh"

module tte_checker import tte_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    `TTE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `TTE_ASSERT_NOW(a_none_blk, m_tvalid && m_tuser == KIND_NONE, m_tdata[15:0] == 16'd0, "block number without a send")
    `TTE_ASSERT_NOW(a_len_data, m_tvalid && m_tuser != KIND_DATA, m_tdata[26:16] == 11'd0, "length outside data send")
    `TTE_ASSERT_NOW(a_store_ack, m_tvalid && m_tdata[27], m_tuser == KIND_ACK, "store without ack")
    `TTE_ASSERT_NOW(a_want, m_tvalid && m_tdata[28], m_tuser == KIND_NONE && m_tdata[31:29] == ST_ACTIVE, "chunk request while sending or inactive")

endmodule

bind tftp_transfer_engine tte_checker u_tte_checker (.*);

`default_nettype wire
